/* design/mtfc_pkg.sv */
package mtfc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_BTN1   = 2'd0;
    localparam logic [1:0] KIND_BTN2   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    localparam logic [15:0] HOLD_RESET     = 16'd3000;
    localparam logic [6:0]  SETPOINT_RESET = 7'd99;
    localparam logic [6:0]  SHOWN_MAX      = 7'd99;
    localparam logic [3:0]  DIGIT_BLANK    = 4'd10;

    // led bit order: red, green, blue
    localparam logic [2:0] LED_NONE  = 3'b000;
    localparam logic [2:0] LED_RED   = 3'b100;
    localparam logic [2:0] LED_GREEN = 3'b010;
    localparam logic [2:0] LED_BLUE  = 3'b001;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_MOTION = 2'd1,
        MODE_THERMO = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        motion_seen;
        logic [11:0] temp_code;
        logic [11:0] speed_knob;
        logic [11:0] setpoint_knob;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [6:0] fan_duty;
        logic       led_red;
        logic       led_green;
        logic       led_blue;
        logic [3:0] tens_digit;
        logic [3:0] ones_digit;
        logic [1:0] mode;
        logic [6:0] setpoint;
        logic [8:0] temp_f;
    } out_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic        motion_seen;
        logic [31:0] now_ms;
        logic [8:0]  temp_val;
        logic [6:0]  sp_val;
        logic [6:0]  duty_val;
    } item_t;

endpackage

/* design/mtfc_front.sv */
module mtfc_front (
    input  mtfc_pkg::in_t   in_data,
    output mtfc_pkg::item_t item
);

    logic [21:0] temp_prod;
    logic [21:0] temp_diff;
    logic [8:0]  temp_val;
    logic [12:0] knob_inv;
    logic [18:0] sp_num;
    logic [6:0]  sp_q0;
    logic [12:0] sp_rem;
    logic [6:0]  sp_val;
    logic [11:0] speed_inv;
    logic [30:0] duty_num;

    // temp = floor((2437120 - 891*code) / 8192), clamped at zero
    assign temp_prod = {10'd0, in_data.temp_code} * 22'd891;
    assign temp_diff = 22'd2437120 - temp_prod;
    assign temp_val  = (temp_prod > 22'd2437120) ? 9'd0 : temp_diff[21:13];

    // divide by 4095: estimate by 4096, then one correction step
    assign knob_inv = 13'd4125 - {1'b0, in_data.setpoint_knob};
    assign sp_num   = {6'd0, knob_inv} * 19'd99;
    assign sp_q0    = sp_num[18:12];
    assign sp_rem   = {1'b0, sp_num[11:0]} + {6'd0, sp_q0};
    assign sp_val   = (sp_rem >= 13'd4095) ? sp_q0 + 7'd1 : sp_q0;

    // duty = (100*2200*4096 + 189500*(4095-knob)) >> 24
    assign speed_inv = 12'd4095 - in_data.speed_knob;
    assign duty_num  = 31'd901120000 + {19'd0, speed_inv} * 31'd189500;

    always_comb
    begin
        item.kind        = in_data.kind;
        item.motion_seen = in_data.motion_seen;
        item.now_ms      = in_data.now_ms;
        item.temp_val    = temp_val;
        item.sp_val      = sp_val;
        item.duty_val    = duty_num[30:24];
    end

endmodule

/* design/mtfc_queue.sv */
module mtfc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mtfc_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output mtfc_pkg::item_t head
);

    mtfc_pkg::item_t                    slot_reg [mtfc_pkg::QUEUE_DEPTH];
    logic [mtfc_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [mtfc_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [mtfc_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [mtfc_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [mtfc_pkg::QCNT_W-1:0]        count_reg;
    logic [mtfc_pkg::QCNT_W-1:0]        count_next;

    assign full      = (count_reg == mtfc_pkg::QCNT_W'(mtfc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mtfc_pkg::QPTR_W'(mtfc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mtfc_pkg::QPTR_W'(mtfc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* design/mtfc_back.sv */
module mtfc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic [15:0]     cfg_data,
    input  logic            q_valid,
    input  mtfc_pkg::item_t q_item,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output mtfc_pkg::out_t  out_data
);

    mtfc_pkg::mode_t mode_reg;
    mtfc_pkg::mode_t mode_next;
    logic            editing_reg;
    logic            editing_next;
    logic            fan_reg;
    logic            fan_next;
    logic [31:0]     deadline_reg;
    logic [31:0]     deadline_next;
    logic [6:0]      setpoint_reg;
    logic [6:0]      setpoint_next;
    logic [8:0]      temp_reg;
    logic [8:0]      temp_next;
    logic [6:0]      shown_reg;
    logic [6:0]      shown_next;
    logic [2:0]      led_reg;
    logic [2:0]      led_next;
    logic [6:0]      duty_reg;
    logic [6:0]      duty_next;
    logic [15:0]     hold_reg;
    logic            out_valid_reg;
    mtfc_pkg::out_t  out_reg;
    mtfc_pkg::out_t  out_next;
    logic [14:0]     tens_prod;
    logic [3:0]      tens_raw;
    logic [3:0]      ones_raw;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // mode sequence on button one
    always_comb
    begin
        mode_next = mode_reg;
        if (q_pop && q_item.kind == mtfc_pkg::KIND_BTN1)
        begin
            unique case (mode_reg)
                mtfc_pkg::MODE_OFF:    mode_next = mtfc_pkg::MODE_MOTION;
                mtfc_pkg::MODE_MOTION: mode_next = mtfc_pkg::MODE_THERMO;
                default:               mode_next = mtfc_pkg::MODE_OFF;
            endcase
        end
    end

    // datapath state and result word
    always_comb
    begin
        editing_next  = editing_reg;
        fan_next      = fan_reg;
        deadline_next = deadline_reg;
        setpoint_next = setpoint_reg;
        temp_next     = temp_reg;
        shown_next    = shown_reg;
        led_next      = led_reg;
        duty_next     = duty_reg;
        if (q_pop)
        begin
            unique case (q_item.kind)
                mtfc_pkg::KIND_BTN1:
                begin
                    unique case (mode_reg)
                        mtfc_pkg::MODE_OFF:
                        begin
                            led_next = mtfc_pkg::LED_GREEN;
                        end
                        mtfc_pkg::MODE_MOTION:
                        begin
                            fan_next = (temp_reg >= {2'b00, setpoint_reg});
                            led_next = mtfc_pkg::LED_BLUE;
                        end
                        default:
                        begin
                            fan_next = 1'b0;
                            led_next = mtfc_pkg::LED_NONE;
                        end
                    endcase
                end
                mtfc_pkg::KIND_BTN2:
                begin
                    editing_next = (mode_reg == mtfc_pkg::MODE_THERMO) && !editing_reg;
                end
                mtfc_pkg::KIND_SAMPLE:
                begin
                    if (!editing_reg)
                    begin
                        temp_next  = q_item.temp_val;
                        shown_next = (q_item.temp_val > {2'b00, mtfc_pkg::SHOWN_MAX})
                                     ? mtfc_pkg::SHOWN_MAX : q_item.temp_val[6:0];
                    end
                    else if (mode_reg == mtfc_pkg::MODE_THERMO)
                    begin
                        setpoint_next = q_item.sp_val;
                        shown_next    = q_item.sp_val;
                    end
                    if (mode_reg == mtfc_pkg::MODE_MOTION)
                    begin
                        if (q_item.motion_seen)
                        begin
                            fan_next      = 1'b1;
                            led_next      = mtfc_pkg::LED_GREEN;
                            deadline_next = q_item.now_ms + {16'd0, hold_reg};
                        end
                        else if (q_item.now_ms > deadline_reg)
                        begin
                            fan_next = 1'b0;
                            led_next = mtfc_pkg::LED_RED;
                        end
                    end
                    if (mode_reg == mtfc_pkg::MODE_THERMO)
                    begin
                        fan_next = (temp_next >= {2'b00, setpoint_next});
                        led_next = fan_next ? (mtfc_pkg::LED_BLUE | mtfc_pkg::LED_GREEN)
                                            : mtfc_pkg::LED_BLUE;
                    end
                    duty_next = fan_next ? q_item.duty_val : 7'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // split the shown value into digits: v/10 == (v*205)>>11 below 179
    assign tens_prod = {8'd0, shown_next} * 15'd205;
    assign tens_raw  = tens_prod[14:11];
    assign ones_raw  = 4'(shown_next - {3'd0, tens_raw} * 7'd10);

    always_comb
    begin
        out_next.fan_duty   = duty_next;
        out_next.led_red    = led_next[2];
        out_next.led_green  = led_next[1];
        out_next.led_blue   = led_next[0];
        out_next.tens_digit = tens_raw;
        out_next.ones_digit = ones_raw;
        if (tens_raw == 4'd0)
        begin
            out_next.tens_digit = mtfc_pkg::DIGIT_BLANK;
            if (ones_raw == 4'd0)
            begin
                out_next.ones_digit = mtfc_pkg::DIGIT_BLANK;
            end
        end
        out_next.mode     = mode_next;
        out_next.setpoint = setpoint_next;
        out_next.temp_f   = temp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= mtfc_pkg::MODE_OFF;
            editing_reg   <= 1'b0;
            fan_reg       <= 1'b0;
            deadline_reg  <= '0;
            setpoint_reg  <= mtfc_pkg::SETPOINT_RESET;
            temp_reg      <= '0;
            shown_reg     <= '0;
            led_reg       <= mtfc_pkg::LED_NONE;
            duty_reg      <= '0;
            hold_reg      <= mtfc_pkg::HOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            editing_reg  <= editing_next;
            fan_reg      <= fan_next;
            deadline_reg <= deadline_next;
            setpoint_reg <= setpoint_next;
            temp_reg     <= temp_next;
            shown_reg    <= shown_next;
            led_reg      <= led_next;
            duty_reg     <= duty_next;
            if (cfg_valid)
            begin
                hold_reg <= cfg_data;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= out_next;
        end
    end

endmodule

/* design/motion_thermostat_fan_controller.sv */
// channel | signals                        | word
// --------+--------------------------------+---------------------------
// in      | in_valid / in_ready / in_data  | mtfc_pkg::in_t
// out     | out_valid / out_ready / out_data | mtfc_pkg::out_t
// cfg     | cfg_valid / cfg_ready / cfg_data | hold_time_ms, 16 bit
//
// One word per cycle sustained while out_ready is high; a result is valid
// after its word passes the front arithmetic into the two-entry queue, then
// the back state update into the output register. cfg_ready is always high.
// Reset clears mode, queue and output valid; no clearing pass.
// A stalled output stops the back; the queue absorbs two words before
// in_ready drops.
module motion_thermostat_fan_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mtfc_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mtfc_pkg::out_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [15:0]    cfg_data
);

    mtfc_pkg::item_t front_item;
    mtfc_pkg::item_t head_item;
    logic            q_full;
    logic            q_not_empty;
    logic            q_pop;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;

    mtfc_front u_front (
        .in_data (in_data),
        .item    (front_item)
    );

    mtfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_item)
    );

    mtfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_not_empty),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mode == mtfc_pkg::MODE_OFF |->
            !out_data.led_red && !out_data.led_green && !out_data.led_blue)
        else $error("LED lit in off mode");

    a_thermo_blue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mode == mtfc_pkg::MODE_THERMO |->
            out_data.led_blue && !out_data.led_red)
        else $error("thermostat mode without blue LED");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.fan_duty <= 7'd100 && out_data.setpoint <= 7'd99)
        else $error("duty or set-point out of range");

endmodule

/* tb/sv/motion_thermostat_fan_controller_tb.sv */
module motion_thermostat_fan_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         TAIL_CYCLES  = 20;
    localparam int         PRESSURE_LEN = 64;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    mtfc_pkg::in_t    in_data;
    logic             out_valid;
    logic             out_ready;
    mtfc_pkg::out_t   out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [15:0]      cfg_data;

    // controller state as the block should hold it
    mtfc_pkg::mode_t  st_mode;
    logic             st_editing;
    logic             st_fan;
    logic [31:0]      st_deadline;
    logic [6:0]       st_setpoint;
    logic [8:0]       st_temp;
    logic [6:0]       st_shown;
    logic [2:0]       st_leds;
    logic [6:0]       st_duty;
    logic [15:0]      hold_ms;

    mtfc_pkg::out_t   expected_panel[$];
    int               mismatches;
    int               cycle_count;
    int               hold_off_left;
    int               ready_gap;
    bit               full_rate;
    logic [31:0]      sim_now;

    motion_thermostat_fan_controller DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // advance the controller state by one word and return the panel it shows
    function automatic mtfc_pkg::out_t panel_after(mtfc_pkg::in_t w);
        mtfc_pkg::out_t r;
        longint         t;
        longint         num;
        int             knob;
        int             speed;
        logic [3:0]     tens;
        logic [3:0]     ones;
        knob  = w.setpoint_knob;
        speed = w.speed_knob;
        case (w.kind)
            mtfc_pkg::KIND_BTN1:
            begin
                case (st_mode)
                    mtfc_pkg::MODE_OFF:
                    begin
                        st_mode = mtfc_pkg::MODE_MOTION;
                        st_leds = mtfc_pkg::LED_GREEN;
                    end
                    mtfc_pkg::MODE_MOTION:
                    begin
                        st_mode = mtfc_pkg::MODE_THERMO;
                        st_fan  = st_temp >= st_setpoint;
                        st_leds = mtfc_pkg::LED_BLUE;
                    end
                    default:
                    begin
                        st_mode = mtfc_pkg::MODE_OFF;
                        st_fan  = 1'b0;
                        st_leds = mtfc_pkg::LED_NONE;
                    end
                endcase
            end
            mtfc_pkg::KIND_BTN2:
                st_editing = (st_mode == mtfc_pkg::MODE_THERMO) && !st_editing;
            mtfc_pkg::KIND_SAMPLE:
            begin
                if (!st_editing)
                begin
                    t = 64'sd2437120 - 64'sd891 * longint'(w.temp_code);
                    st_temp  = (t < 0) ? 9'd0 : 9'(t / 8192);
                    st_shown = (st_temp > mtfc_pkg::SHOWN_MAX) ? mtfc_pkg::SHOWN_MAX
                                                               : 7'(st_temp);
                end
                else if (st_mode == mtfc_pkg::MODE_THERMO)
                begin
                    st_setpoint = 7'(((4125 - knob) * 99) / 4095);
                    st_shown    = st_setpoint;
                end
                if (st_mode == mtfc_pkg::MODE_MOTION)
                begin
                    if (w.motion_seen)
                    begin
                        st_fan      = 1'b1;
                        st_leds     = mtfc_pkg::LED_GREEN;
                        st_deadline = w.now_ms + {16'd0, hold_ms};
                    end
                    else if (w.now_ms > st_deadline)
                    begin
                        st_fan  = 1'b0;
                        st_leds = mtfc_pkg::LED_RED;
                    end
                end
                if (st_mode == mtfc_pkg::MODE_THERMO)
                begin
                    st_fan  = st_temp >= st_setpoint;
                    st_leds = st_fan ? (mtfc_pkg::LED_BLUE | mtfc_pkg::LED_GREEN)
                                     : mtfc_pkg::LED_BLUE;
                end
                if (st_fan)
                begin
                    num     = 64'd9011200 + 64'd1895 * longint'(4095 - speed);
                    st_duty = 7'((num * 100) >> 24);
                end
                else
                    st_duty = 7'd0;
            end
            default:
                ;
        endcase
        tens = 4'(st_shown / 10);
        ones = 4'(st_shown % 10);
        if (tens == 4'd0)
        begin
            tens = mtfc_pkg::DIGIT_BLANK;
            if (ones == 4'd0)
                ones = mtfc_pkg::DIGIT_BLANK;
        end
        r.fan_duty   = st_duty;
        r.led_red    = |(st_leds & mtfc_pkg::LED_RED);
        r.led_green  = |(st_leds & mtfc_pkg::LED_GREEN);
        r.led_blue   = |(st_leds & mtfc_pkg::LED_BLUE);
        r.tens_digit = tens;
        r.ones_digit = ones;
        r.mode       = st_mode;
        r.setpoint   = st_setpoint;
        r.temp_f     = st_temp;
        return r;
    endfunction

    function automatic mtfc_pkg::in_t word_of(logic [1:0] k, logic m, logic [11:0] code,
                                              logic [11:0] speed, logic [11:0] knob,
                                              logic [31:0] now);
        mtfc_pkg::in_t w;
        w.kind          = k;
        w.motion_seen   = m;
        w.temp_code     = code;
        w.speed_knob    = speed;
        w.setpoint_knob = knob;
        w.now_ms        = now;
        return w;
    endfunction

    // mostly samples on a running clock, with button presses and stray words mixed in
    function automatic mtfc_pkg::in_t random_word();
        mtfc_pkg::in_t w;
        int unsigned   r;
        r = $urandom_range(0, 99);
        if (r < 68)
            w.kind = mtfc_pkg::KIND_SAMPLE;
        else if (r < 81)
            w.kind = mtfc_pkg::KIND_BTN1;
        else if (r < 95)
            w.kind = mtfc_pkg::KIND_BTN2;
        else
            w.kind = KIND_UNUSED;
        w.motion_seen = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 3) == 0)
            w.temp_code = 12'($urandom_range(1900, 2700));
        else
            w.temp_code = 12'($urandom);
        w.speed_knob    = 12'($urandom);
        w.setpoint_knob = 12'($urandom);
        if ($urandom_range(0, 4) == 0)
            w.now_ms = $urandom;
        else
        begin
            sim_now  = sim_now + $urandom_range(0, hold_ms + hold_ms / 2 + 16);
            w.now_ms = sim_now;
        end
        return w;
    endfunction

    task automatic send_word(mtfc_pkg::in_t w);
        int gap;
        gap = full_rate ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        expected_panel.push_back(panel_after(w));
    endtask

    task automatic drain_results();
        @(negedge clk) in_valid <= 1'b0;
        while (expected_panel.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_hold_time(logic [15:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        hold_ms = value;
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string name, int unsigned e, int unsigned a);
        if (e != a)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
        end
    endtask

    always @(posedge clk)
    begin
        mtfc_pkg::out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_panel.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word with nothing expected, actual %h", $time, out_data);
            end
            else
            begin
                e = expected_panel.pop_front();
                check_field("fan_duty", e.fan_duty, out_data.fan_duty);
                check_field("led_red", e.led_red, out_data.led_red);
                check_field("led_green", e.led_green, out_data.led_green);
                check_field("led_blue", e.led_blue, out_data.led_blue);
                check_field("tens_digit", e.tens_digit, out_data.tens_digit);
                check_field("ones_digit", e.ones_digit, out_data.ones_digit);
                check_field("mode", e.mode, out_data.mode);
                check_field("setpoint", e.setpoint, out_data.setpoint);
                check_field("temp_f", e.temp_f, out_data.temp_f);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                out_ready <= 1'b0;
                hold_off_left--;
            end
            else if (full_rate)
                out_ready <= 1'b1;
            else if (ready_gap > 0)
            begin
                out_ready <= 1'b0;
                ready_gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    ready_gap = pick_gap();
            end
        end
    end

    task automatic test_directed();
        // unused kind from reset, then display extremes in off mode
        send_word(word_of(KIND_UNUSED, 1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b0, 12'd0, 12'd0, 12'd0, 32'd0));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 32'd50));
        // editing cannot start outside thermostat mode
        send_word(word_of(mtfc_pkg::KIND_BTN2, 1'b0, 12'd0, 12'd0, 12'd0, 32'd60));
        send_word(word_of(mtfc_pkg::KIND_BTN1, 1'b0, 12'd0, 12'd0, 12'd0, 32'd70));
        // motion hold: deadline reached but not passed, then passed
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b1, 12'd2000, 12'd0, 12'd0, 32'd100));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b0, 12'd2000, 12'd100, 12'd0, 32'd3100));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b0, 12'd2000, 12'd100, 12'd0, 32'd3101));
        // deadline wraps past 2^32
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b1, 12'd1000, 12'd500, 12'd0,
                          32'hFFFF_FF00));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b0, 12'd1000, 12'd500, 12'd0,
                          32'hFFFF_FFFF));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b1, 12'd0, 12'hFFF, 12'd0, 32'd5000));
        // enter thermostat with the fan running
        send_word(word_of(mtfc_pkg::KIND_BTN1, 1'b0, 12'd0, 12'd0, 12'd0, 32'd5010));
        send_word(word_of(mtfc_pkg::KIND_BTN2, 1'b0, 12'd0, 12'd0, 12'd0, 32'd5020));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b0, 12'd0, 12'd0, 12'hFFF, 32'd5030));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b0, 12'd0, 12'd0, 12'd0, 32'd5040));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b0, 12'd0, 12'd2048, 12'd2048, 32'd5050));
        send_word(word_of(mtfc_pkg::KIND_BTN2, 1'b0, 12'd0, 12'd0, 12'd0, 32'd5060));
        // temperature equal to the set-point, then just below it
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b0, 12'd2270, 12'd1234, 12'd0, 32'd5070));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b0, 12'd2300, 12'd1234, 12'd0, 32'd5080));
        // leave thermostat while editing, sample in off, then clear editing
        send_word(word_of(mtfc_pkg::KIND_BTN2, 1'b0, 12'd0, 12'd0, 12'd0, 32'd5090));
        send_word(word_of(mtfc_pkg::KIND_BTN1, 1'b0, 12'd0, 12'd0, 12'd0, 32'd5100));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b1, 12'd100, 12'd100, 12'd100, 32'd5110));
        send_word(word_of(mtfc_pkg::KIND_BTN2, 1'b0, 12'd0, 12'd0, 12'd0, 32'd5120));
        send_word(word_of(mtfc_pkg::KIND_SAMPLE, 1'b0, 12'd3000, 12'd3000, 12'd3000,
                          32'd5130));
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_word(random_word());
    endtask

    task automatic test_full_rate(int count);
        full_rate = 1'b1;
        repeat (count) send_word(random_word());
        full_rate = 1'b0;
    endtask

    // hold the result side off while words keep coming, then wait for all results
    task automatic test_back_pressure();
        drain_results();
        full_rate     = 1'b1;
        hold_off_left = PRESSURE_LEN;
        repeat (16) send_word(random_word());
        full_rate = 1'b0;
        drain_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        mismatches    = 0;
        cycle_count   = 0;
        hold_off_left = 0;
        ready_gap     = 0;
        full_rate     = 1'b0;
        sim_now       = 32'd0;
        hold_ms       = mtfc_pkg::HOLD_RESET;
        st_mode       = mtfc_pkg::MODE_OFF;
        st_editing    = 1'b0;
        st_fan        = 1'b0;
        st_deadline   = 32'd0;
        st_setpoint   = mtfc_pkg::SETPOINT_RESET;
        st_temp       = 9'd0;
        st_shown      = 7'd0;
        st_leds       = mtfc_pkg::LED_NONE;
        st_duty       = 7'd0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        write_hold_time(mtfc_pkg::HOLD_RESET);
        test_directed();
        test_random_traffic(275);
        write_hold_time(16'd0);
        test_random_traffic(275);
        test_back_pressure();
        write_hold_time(16'hFFFF);
        test_random_traffic(275);
        write_hold_time(16'($urandom_range(1, 16'hFFFE)));
        test_full_rate(100);
        test_random_traffic(180);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
